>>> rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the ring fork arbiter
// Field widths, command codes, register map and the command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rfa_pkg;

  localparam int CMD_W         = 2;
  localparam int SEAT_W        = 4;
  localparam int CNT_W         = 5;
  localparam int PRIO_W        = 5;
  localparam int DEF_MAX_SEATS = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index, taken from the word address
  localparam logic REG_SEAT_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  localparam logic [CMD_W-1:0] CMD_TRY     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DROP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GIVE_UP = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [CMD_W-1:0]  cmd;
    logic [SEAT_W-1:0] seat;
  } op_t;

endpackage

`default_nettype wire

>>> rtl/rfa_cfg.sv
// ----------------------------------------------------------------------------
// rfa_cfg: configuration register block
// Holds the seat count, clamped into the supported range on write.
// ----------------------------------------------------------------------------
`default_nettype none

module rfa_cfg #(
  parameter int MAX_SEATS = rfa_pkg::DEF_MAX_SEATS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [rfa_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [rfa_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [rfa_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output logic      [rfa_pkg::CNT_W-1:0]  seat_count
);
  import rfa_pkg::*;

  localparam int CNT_TOP = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_MAX =
    (MAX_SEATS > CNT_TOP) ? CNT_W'(CNT_TOP) : CNT_W'(MAX_SEATS);

  logic [CNT_W-1:0] seat_count_r, seat_count_nxt;
  logic [CNT_W-1:0] wr_val;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_SEAT_COUNT);
  assign wr_val = cfg_pwdata[CNT_W-1:0];

  always_comb begin
    seat_count_nxt = seat_count_r;
    if (wr_en) begin
      if (wr_val < CNT_MIN) begin
        seat_count_nxt = CNT_MIN;
      end else if (wr_val > CNT_MAX) begin
        seat_count_nxt = CNT_MAX;
      end else begin
        seat_count_nxt = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seat_count_r <= CNT_RESET;
    end else begin
      seat_count_r <= seat_count_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SEAT_COUNT) begin
      cfg_prdata = CFG_DW'(seat_count_r);
    end
  end

  assign seat_count = seat_count_r;

endmodule

`default_nettype wire

>>> rtl/rfa_table.sv
// ----------------------------------------------------------------------------
// rfa_table: resource and seat state with per-seat grant lanes
// Each lane checks its two resources in parallel; the command picks a lane
// and updates the two resource entries and the seat flag it touches.
// ----------------------------------------------------------------------------
`default_nettype none

module rfa_table #(
  parameter int MAX_SEATS = rfa_pkg::DEF_MAX_SEATS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rfa_pkg::op_t              op,
  input  wire logic [rfa_pkg::CNT_W-1:0] seat_count,
  output logic                           grant
);
  import rfa_pkg::*;

  // seats that can issue commands, and resources they can reach
  localparam int SEATS_ADDR = 1 << SEAT_W;
  localparam int LANES  = (MAX_SEATS < SEATS_ADDR) ? MAX_SEATS : SEATS_ADDR;
  localparam int RES    = (MAX_SEATS < SEATS_ADDR + 1) ? MAX_SEATS : SEATS_ADDR + 1;
  localparam int LANE_W = $clog2(LANES);
  localparam int RES_W  = $clog2(RES);
  localparam int LANE_PAD = 1 << LANE_W;

  logic [RES-1:0]    in_use_r, in_use_nxt;
  logic [PRIO_W-1:0] prio_r   [RES];
  logic [PRIO_W-1:0] prio_nxt [RES];
  logic [LANES-1:0]  wait_r, wait_nxt;
  logic [LANE_PAD-1:0] lane_ok;

  logic [CNT_W-1:0]  seat_ext, right_c, lrival_c, last_seat;
  logic [PRIO_W-1:0] prio_left_val, prio_right_val;
  logic [RES_W-1:0]  left_idx, right_idx;
  logic              seat_ok, go, last_waiting;

  assign last_seat = seat_count - CNT_W'(1);
  // waiting mark of the highest seat, the left rival of seat zero
  assign last_waiting = (last_seat < CNT_W'(LANES)) ? wait_r[LANE_W'(last_seat)] : 1'b0;

  genvar i;
  generate
    for (i = 0; i < LANE_PAD; i++) begin : g_lane
      if (i < LANES) begin : g_live
        localparam int NEXT_R = (i + 1 < RES) ? i + 1 : 0;
        logic              wrap;
        logic              r_use;
        logic [PRIO_W-1:0] r_prio;
        logic              r_rival_wait;
        logic              l_rival_wait;
        logic              l_ok, r_ok;

        assign wrap   = (seat_count == CNT_W'(i + 1));
        assign r_use  = wrap ? in_use_r[0] : in_use_r[NEXT_R];
        assign r_prio = wrap ? prio_r[0] : prio_r[NEXT_R];

        if (i + 1 < LANES) begin : g_nr
          assign r_rival_wait = wrap ? wait_r[0] : wait_r[i + 1];
        end else begin : g_nr_none
          assign r_rival_wait = wrap ? wait_r[0] : 1'b0;
        end

        if (i == 0) begin : g_lr0
          assign l_rival_wait = last_waiting;
        end else begin : g_lr
          assign l_rival_wait = wait_r[i - 1];
        end

        assign l_ok = !in_use_r[i] && (prio_r[i] == '0 || prio_r[i] == PRIO_W'(i + 1)
                                       || !l_rival_wait);
        assign r_ok = !r_use && (r_prio == '0 || r_prio == PRIO_W'(i + 1)
                                 || !r_rival_wait);
        assign lane_ok[i] = l_ok && r_ok;
      end else begin : g_pad
        assign lane_ok[i] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    seat_ext = {1'b0, op.seat};
    seat_ok  = seat_ext < seat_count;
    go       = op.valid && seat_ok;
    right_c  = (seat_ext + CNT_W'(1) == seat_count) ? '0 : seat_ext + CNT_W'(1);
    lrival_c = (seat_ext == '0) ? last_seat : seat_ext - CNT_W'(1);
    prio_left_val  = PRIO_W'(lrival_c + CNT_W'(1));
    prio_right_val = PRIO_W'(right_c + CNT_W'(1));
    left_idx  = RES_W'(seat_ext);
    right_idx = RES_W'(right_c);
    grant = go && (op.cmd == CMD_TRY) && lane_ok[op.seat[LANE_W-1:0]];
  end

  always_comb begin
    in_use_nxt = in_use_r;
    wait_nxt   = wait_r;
    for (int j = 0; j < RES; j++) begin
      prio_nxt[j] = prio_r[j];
    end
    if (go) begin
      case (op.cmd)
        CMD_TRY: begin
          for (int j = 0; j < LANES; j++) begin
            if (LANE_W'(j) == op.seat[LANE_W-1:0]) begin
              wait_nxt[j] = !grant;
            end
          end
          for (int j = 0; j < RES; j++) begin
            if (grant && (RES_W'(j) == left_idx || RES_W'(j) == right_idx)) begin
              in_use_nxt[j] = 1'b1;
            end
          end
        end
        CMD_DROP: begin
          // free both and hand priority to the neighbour sharing each one
          for (int j = 0; j < RES; j++) begin
            if (RES_W'(j) == left_idx) begin
              in_use_nxt[j] = 1'b0;
              prio_nxt[j]   = prio_left_val;
            end
            if (RES_W'(j) == right_idx) begin
              in_use_nxt[j] = 1'b0;
              prio_nxt[j]   = prio_right_val;
            end
          end
        end
        CMD_GIVE_UP: begin
          for (int j = 0; j < LANES; j++) begin
            if (LANE_W'(j) == op.seat[LANE_W-1:0]) begin
              wait_nxt[j] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      wait_r   <= '0;
      for (int j = 0; j < RES; j++) begin
        prio_r[j] <= '0;
      end
    end else begin
      in_use_r <= in_use_nxt;
      wait_r   <= wait_nxt;
      for (int j = 0; j < RES; j++) begin
        prio_r[j] <= prio_nxt[j];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ring_fork_arbiter.sv
// ----------------------------------------------------------------------------
// ring_fork_arbiter: fair arbiter for a ring of seats sharing resources
//
//   channel   dir   handshake             payload
//   in_       in    in_tvalid/in_tready   tdata: command, seat_index
//   out_      out   out_tvalid/out_tready tdata: granted
//   cfg_      in    psel/penable/pready   seat_count at byte address 0
//
// One command per cycle is taken while the output does not stall; each passes an
// input register, is decided and applied to the state as it moves into the
// result register. Reset clears all resource and seat state and sets the seat
// count to two. A stall on the output holds the result register and then the
// input register; state changes only when a command moves into the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fork_arbiter #(
  parameter int MAX_SEATS = rfa_pkg::DEF_MAX_SEATS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [1:0] command, [5:2] seat_index, [7:6] zero
  input  wire logic [rfa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [0] granted, [7:1] zero
  output logic      [rfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [rfa_pkg::CFG_AW-1:0]      cfg_paddr,
  input  wire logic [rfa_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic      [rfa_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import rfa_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [SEAT_W-1:0] seat_r;
  logic              out_valid_r, out_valid_nxt;
  logic              granted_r;
  logic              advance, fire, grant;
  logic [CNT_W-1:0]  seat_count;
  op_t               op;

  rfa_cfg #(
    .MAX_SEATS (MAX_SEATS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .seat_count  (seat_count)
  );

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign op.valid = fire;
  assign op.cmd   = cmd_r;
  assign op.seat  = seat_r;

  rfa_table #(
    .MAX_SEATS (MAX_SEATS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .seat_count (seat_count),
    .grant      (grant)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tdata[CMD_W-1:0];
      seat_r <= in_tdata[CMD_W+SEAT_W-1:CMD_W];
    end
    if (fire) begin
      granted_r <= grant;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, granted_r};

endmodule

`default_nettype wire
